/* rtl/core/mpeg_audio_header_decode_unit_assert.svh */
// Assertion macros used by the checker of the header decode unit.
// Both sample on clk and are turned off while rst_n is low.
`ifndef MPEG_AUDIO_HEADER_DECODE_UNIT_ASSERT_SVH
`define MPEG_AUDIO_HEADER_DECODE_UNIT_ASSERT_SVH

// Any property that starts from the current edge.
`define MAHD_ASSERT_PROP(name, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("mahd assertion failed");

// Condition at one edge implies a consequence at the same edge.
`define MAHD_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mahd implication failed");

`endif

/* rtl/core/mahd_pkg.sv */
package mahd_pkg;

    localparam logic [31:0] SYNC_MASK = 32'hFFE0_0000;

    // Version field codes
    localparam logic [1:0] VER_MPEG1    = 2'b11;
    localparam logic [1:0] VER_MPEG2    = 2'b10;
    localparam logic [1:0] VER_MPEG25   = 2'b00;
    localparam logic [1:0] VER_RESERVED = 2'b01;

    localparam logic [1:0] LAYER_RESERVED = 2'b00;
    localparam logic [1:0] LAYER_ONE      = 2'd1;
    localparam logic [1:0] LAYER_TWO      = 2'd2;

    localparam logic [3:0] BIDX_FREE = 4'd0;
    localparam logic [3:0] BIDX_BAD  = 4'd15;
    localparam logic [1:0] RIDX_RESERVED = 2'd3;
    localparam logic [1:0] MODE_MONO = 2'b11;

    localparam logic [10:0] SPF_L1   = 11'd384;
    localparam logic [10:0] SPF_LONG = 11'd1152;
    localparam logic [10:0] SPF_LSF  = 11'd576;

    localparam logic [5:0] OFF_SMALL = 6'h09;
    localparam logic [5:0] OFF_MID   = 6'h11;
    localparam logic [5:0] OFF_LARGE = 6'h20;

    // Bytes-per-kbps scale factors (bits per second times the layer constant)
    localparam int K_W = 18;
    localparam logic [K_W-1:0] K_L1    = 18'd12000;
    localparam logic [K_W-1:0] K_LONG  = 18'd144000;
    localparam logic [K_W-1:0] K_L3LSF = 18'd72000;

    // Datapath widths: bitrate, numerator, reciprocal, quotient, sample rate
    localparam int KBPS_W = 9;
    localparam int M_W    = 27;
    localparam int R_W    = 29;
    localparam int Q_W    = 12;
    localparam int FS_W   = 16;
    localparam int RSHIFT = 43;
    localparam int P_W    = M_W + R_W;
    localparam int QB_W   = Q_W + FS_W;

    typedef enum logic [2:0] {
        ERR_NONE     = 3'd0,
        ERR_SYNC     = 3'd1,
        ERR_VERSION  = 3'd2,
        ERR_LAYER    = 3'd3,
        ERR_BITRATE  = 3'd4,
        ERR_RATE     = 3'd5,
        ERR_EMPHASIS = 3'd6
    } err_t;

    // Per-item side data that rides along the divide pipeline
    typedef struct packed {
        logic            ok;
        err_t            err;
        logic [1:0]      layer;
        logic            pad;
        logic [10:0]     spf;
        logic [FS_W-1:0] fs;
        logic [5:0]      off;
        logic [1:0]      ridx;
    } meta_t;

    localparam logic [KBPS_W-1:0] KBPS_V1_L1 [0:15] = '{
        9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
        9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0};
    localparam logic [KBPS_W-1:0] KBPS_V1_L2 [0:15] = '{
        9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
        9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0};
    localparam logic [KBPS_W-1:0] KBPS_V1_L3 [0:15] = '{
        9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
        9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0};
    localparam logic [KBPS_W-1:0] KBPS_V2_L1 [0:15] = '{
        9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
        9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0};
    localparam logic [KBPS_W-1:0] KBPS_V2_L23 [0:15] = '{
        9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
        9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0};

    // lidx: 0 for layer I, 1 for layer II, 2 for layer III
    function automatic logic [KBPS_W-1:0] kbps_lookup(input logic lsf,
                                                      input logic [1:0] lidx,
                                                      input logic [3:0] bidx);
        logic [KBPS_W-1:0] v;
        case ({lsf, lidx})
            3'b000:  v = KBPS_V1_L1[bidx];
            3'b001:  v = KBPS_V1_L2[bidx];
            3'b010:  v = KBPS_V1_L3[bidx];
            3'b100:  v = KBPS_V2_L1[bidx];
            3'b101:  v = KBPS_V2_L23[bidx];
            3'b110:  v = KBPS_V2_L23[bidx];
            default: v = '0;
        endcase
        return v;
    endfunction

    // MPEG-1 sample rate; lower versions divide it by 2 or 4
    function automatic logic [FS_W-1:0] base_fs(input logic [1:0] ridx);
        logic [FS_W-1:0] v;
        case (ridx)
            2'd0:    v = 16'd44100;
            2'd1:    v = 16'd48000;
            2'd2:    v = 16'd32000;
            default: v = 16'd32000;
        endcase
        return v;
    endfunction

    // floor(2^RSHIFT / base_fs)
    function automatic logic [R_W-1:0] recip_fs(input logic [1:0] ridx);
        logic [R_W-1:0] v;
        case (ridx)
            2'd0:    v = 29'd199457891;
            2'd1:    v = 29'd183251937;
            2'd2:    v = 29'd274877906;
            default: v = 29'd274877906;
        endcase
        return v;
    endfunction

endpackage

/* rtl/core/mpeg_audio_header_decode_unit.sv */
// MPEG audio frame header decode: one result per request, signalled by the done strobe.
// Throughput: one header word per clock; busy stays low, since the four-stage
// reciprocal-divide pipeline takes a new word every cycle and the receiver cannot stall.
// Latency is set by the two multiplies of the divide (numerator times reciprocal, quotient
// times rate) and the final remainder correction, each in a stage of its own.
// Reset (rst_n low, asynchronous) clears the stage valid bits and done; payload is not reset.
module mpeg_audio_header_decode_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] header_word,
    output logic        done,
    output logic        valid_res,
    output logic [2:0]  error_code,
    output logic [1:0]  layer_num,
    output logic [11:0] frame_bytes,
    output logic [10:0] samples_per_frame,
    output logic [15:0] sample_rate_hz,
    output logic [5:0]  side_info_offset
);

    // ------------------------------------------------------------------
    // Stage 1: check the header, look up tables, form the dividend
    //   frame_len = floor(kbps * K * 2^s / base_fs), where base_fs is the
    //   MPEG-1 rate and s is 0, 1 or 2 for MPEG-1, MPEG-2 and MPEG-2.5.
    // ------------------------------------------------------------------
    logic [1:0]  ver;
    logic [1:0]  lbits;
    logic [3:0]  bidx;
    logic [1:0]  ridx;
    logic [1:0]  mode;
    logic        lsf;
    logic [1:0]  fs_shift;
    logic [1:0]  layer;
    logic [mahd_pkg::KBPS_W-1:0] kbps;
    logic [mahd_pkg::K_W-1:0]    kcoef;
    logic [mahd_pkg::M_W-1:0]    prod0;

    mahd_pkg::meta_t          s1_meta_next;
    logic [mahd_pkg::M_W-1:0] s1_m_next;

    assign ver   = header_word[20:19];
    assign lbits = header_word[18:17];
    assign bidx  = header_word[15:12];
    assign ridx  = header_word[11:10];
    assign mode  = header_word[7:6];
    assign lsf   = (ver != mahd_pkg::VER_MPEG1);
    // layer = 4 - lbits, which in two bits is the negation
    assign layer = 2'(-lbits);

    always_comb
    begin
        case (ver)
            mahd_pkg::VER_MPEG1:  fs_shift = 2'd0;
            mahd_pkg::VER_MPEG2:  fs_shift = 2'd1;
            mahd_pkg::VER_MPEG25: fs_shift = 2'd2;
            default:              fs_shift = 2'd0;
        endcase
    end

    always_comb
    begin
        kbps = mahd_pkg::kbps_lookup(lsf, ~lbits, bidx);

        if (layer == mahd_pkg::LAYER_ONE)
            kcoef = mahd_pkg::K_L1;
        else if (layer == mahd_pkg::LAYER_TWO || !lsf)
            kcoef = mahd_pkg::K_LONG;
        else
            kcoef = mahd_pkg::K_L3LSF;

        prod0     = mahd_pkg::M_W'(kbps) * mahd_pkg::M_W'(kcoef);
        s1_m_next = prod0 << fs_shift;
    end

    // Error priority follows the order of the checks
    always_comb
    begin
        s1_meta_next      = '0;
        s1_meta_next.pad  = header_word[9];
        s1_meta_next.ridx = ridx;
        s1_meta_next.layer = layer;
        s1_meta_next.fs   = mahd_pkg::base_fs(ridx) >> fs_shift;

        if (layer == mahd_pkg::LAYER_ONE)
            s1_meta_next.spf = mahd_pkg::SPF_L1;
        else if (layer == mahd_pkg::LAYER_TWO || !lsf)
            s1_meta_next.spf = mahd_pkg::SPF_LONG;
        else
            s1_meta_next.spf = mahd_pkg::SPF_LSF;

        if (ver == mahd_pkg::VER_MPEG1)
            s1_meta_next.off = (mode == mahd_pkg::MODE_MONO) ? mahd_pkg::OFF_MID
                                                               : mahd_pkg::OFF_LARGE;
        else
            s1_meta_next.off = (mode == mahd_pkg::MODE_MONO) ? mahd_pkg::OFF_SMALL
                                                               : mahd_pkg::OFF_MID;

        if ((header_word & mahd_pkg::SYNC_MASK) != mahd_pkg::SYNC_MASK)
            s1_meta_next.err = mahd_pkg::ERR_SYNC;
        else if (ver == mahd_pkg::VER_RESERVED)
            s1_meta_next.err = mahd_pkg::ERR_VERSION;
        else if (lbits == mahd_pkg::LAYER_RESERVED)
            s1_meta_next.err = mahd_pkg::ERR_LAYER;
        else if (bidx == mahd_pkg::BIDX_FREE || bidx == mahd_pkg::BIDX_BAD)
            s1_meta_next.err = mahd_pkg::ERR_BITRATE;
        else if (ridx == mahd_pkg::RIDX_RESERVED)
            s1_meta_next.err = mahd_pkg::ERR_RATE;
        else if (header_word[1])
            s1_meta_next.err = mahd_pkg::ERR_EMPHASIS;
        else
            s1_meta_next.err = mahd_pkg::ERR_NONE;

        s1_meta_next.ok = (s1_meta_next.err == mahd_pkg::ERR_NONE);
    end

    logic                     s1_vld_reg;
    mahd_pkg::meta_t          s1_meta_reg;
    logic [mahd_pkg::M_W-1:0] s1_m_reg;

    // ------------------------------------------------------------------
    // Stage 2: quotient estimate = (M * floor(2^43/base)) >> 43, which is
    //   the true quotient or one less.
    // ------------------------------------------------------------------
    logic [mahd_pkg::P_W-1:0] p2;
    logic [mahd_pkg::Q_W-1:0] s2_q_next;

    assign p2        = mahd_pkg::P_W'(s1_m_reg) * mahd_pkg::P_W'(mahd_pkg::recip_fs(s1_meta_reg.ridx));
    assign s2_q_next = p2[mahd_pkg::RSHIFT + mahd_pkg::Q_W - 1 : mahd_pkg::RSHIFT];

    logic                     s2_vld_reg;
    mahd_pkg::meta_t          s2_meta_reg;
    logic [mahd_pkg::M_W-1:0] s2_m_reg;
    logic [mahd_pkg::Q_W-1:0] s2_q_reg;

    // ------------------------------------------------------------------
    // Stage 3: multiply the estimate back by the divisor
    // ------------------------------------------------------------------
    logic [mahd_pkg::QB_W-1:0] s3_qb_next;

    assign s3_qb_next = mahd_pkg::QB_W'(s2_q_reg)
                      * mahd_pkg::QB_W'(mahd_pkg::base_fs(s2_meta_reg.ridx));

    logic                      s3_vld_reg;
    mahd_pkg::meta_t           s3_meta_reg;
    logic [mahd_pkg::M_W-1:0]  s3_m_reg;
    logic [mahd_pkg::Q_W-1:0]  s3_q_reg;
    logic [mahd_pkg::QB_W-1:0] s3_qb_reg;

    // ------------------------------------------------------------------
    // Stage 4: correct the quotient by one where the remainder reaches the
    //   divisor, add padding, scale layer I slots to bytes, zero on error.
    // ------------------------------------------------------------------
    logic [mahd_pkg::M_W-1:0] rem4;
    logic [mahd_pkg::Q_W-1:0] q4;
    logic [11:0]              slots4;
    logic [11:0]              frame_bytes_next;

    always_comb
    begin
        rem4   = s3_m_reg - s3_qb_reg[mahd_pkg::M_W-1:0];
        q4     = s3_q_reg
               + mahd_pkg::Q_W'(rem4 >= mahd_pkg::M_W'(mahd_pkg::base_fs(s3_meta_reg.ridx)));
        slots4 = q4 + 12'(s3_meta_reg.pad);
        if (!s3_meta_reg.ok)
            frame_bytes_next = '0;
        else if (s3_meta_reg.layer == mahd_pkg::LAYER_ONE)
            frame_bytes_next = slots4 << 2;
        else
            frame_bytes_next = slots4;
    end

    logic        done_reg;
    logic        valid_res_reg;
    logic [2:0]  error_code_reg;
    logic [1:0]  layer_num_reg;
    logic [11:0] frame_bytes_reg;
    logic [10:0] samples_per_frame_reg;
    logic [15:0] sample_rate_hz_reg;
    logic [5:0]  side_info_offset_reg;

    // Valid bits: one per stage, cleared by reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= start && !busy;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            done_reg   <= s3_vld_reg;
        end
    end

    // Payload: advance every cycle, no reset needed
    always_ff @(posedge clk)
    begin
        s1_meta_reg <= s1_meta_next;
        s1_m_reg    <= s1_m_next;

        s2_meta_reg <= s1_meta_reg;
        s2_m_reg    <= s1_m_reg;
        s2_q_reg    <= s2_q_next;

        s3_meta_reg <= s2_meta_reg;
        s3_m_reg    <= s2_m_reg;
        s3_q_reg    <= s2_q_reg;
        s3_qb_reg   <= s3_qb_next;

        valid_res_reg         <= s3_meta_reg.ok;
        error_code_reg        <= s3_meta_reg.err;
        layer_num_reg         <= s3_meta_reg.ok ? s3_meta_reg.layer : 2'd0;
        frame_bytes_reg       <= frame_bytes_next;
        samples_per_frame_reg <= s3_meta_reg.ok ? s3_meta_reg.spf : 11'd0;
        sample_rate_hz_reg    <= s3_meta_reg.ok ? s3_meta_reg.fs : 16'd0;
        side_info_offset_reg  <= s3_meta_reg.ok ? s3_meta_reg.off : 6'd0;
    end

    // The pipeline takes a request every cycle
    assign busy              = 1'b0;
    assign done              = done_reg;
    assign valid_res         = valid_res_reg;
    assign error_code        = error_code_reg;
    assign layer_num         = layer_num_reg;
    assign frame_bytes       = frame_bytes_reg;
    assign samples_per_frame = samples_per_frame_reg;
    assign sample_rate_hz    = sample_rate_hz_reg;
    assign side_info_offset  = side_info_offset_reg;

endmodule

/* rtl/core/mahd_checker.sv */
`include "mpeg_audio_header_decode_unit_assert.svh"

module mahd_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic        valid_res,
    input logic [2:0]  error_code,
    input logic [1:0]  layer_num,
    input logic [11:0] frame_bytes,
    input logic [10:0] samples_per_frame,
    input logic [15:0] sample_rate_hz,
    input logic [5:0]  side_info_offset
);

    // Every request gives a result, and no result appears without one
    `MAHD_ASSERT_PROP(a_req_gives_done, (start && !busy) |-> ##4 done)
    `MAHD_ASSERT_IMPL(a_done_has_req, done, $past(start && !busy, 4))

    // Valid flag agrees with the error code
    `MAHD_ASSERT_IMPL(a_valid_vs_err, done, valid_res == (error_code == mahd_pkg::ERR_NONE))

    // Rejected headers carry all-zero result fields; accepted ones are nonzero
    `MAHD_ASSERT_IMPL(a_fields_vs_valid, done,
        (valid_res == (layer_num != 2'd0)) && (valid_res == (frame_bytes != 12'd0))
        && (valid_res == (samples_per_frame != 11'd0))
        && (valid_res == (sample_rate_hz != 16'd0))
        && (valid_res == (side_info_offset != 6'd0)))

endmodule

bind mpeg_audio_header_decode_unit mahd_checker u_mahd_checker (.*);
